[design/rhps_pkg.sv]
// rhps_pkg: shared constants, types and helpers of the rolling hash pattern search core
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rhps_pkg;

  // hash arithmetic
  localparam int HASH_W = 30;
  localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000009;
  localparam logic [HASH_W-1:0] HASH_BASE = 30'd31;
  // 'a' maps to 1, so the origin sits one below it
  localparam logic [7:0] CHAR_ORIGIN = 8'd96;

  // barrett reduction of a product below 2^(2*HASH_W)
  localparam int PROD_W = 2 * HASH_W;
  localparam int MU_W = HASH_W + 1;
  localparam logic [MU_W-1:0] BARRETT_MU = MU_W'((64'd1 << PROD_W) / 64'(HASH_MOD));
  // remainder before correction stays below three moduli
  localparam int REM_W = HASH_W + 2;
  localparam logic [REM_W-1:0] MOD_X1 = REM_W'(HASH_MOD);
  localparam logic [REM_W-1:0] MOD_X2 = MOD_X1 << 1;

  // interface widths
  localparam int CHAR_W = 8;
  localparam int LEN_CFG_W = 7;
  localparam int START_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // parameter defaults
  localparam int MAX_PATTERN_DEF = 64;
  localparam int POS_BITS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_HASH   = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_TOP_WEIGHT     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic drop_mul;
    logic red_q1;
    logic red_qm;
    logic red_sub;
    logic red_fix;
    logic hash_mix;
    logic hash_mul;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } ctrl_status_t;

  // byte to residue: byte - 96 taken modulo the hash modulus
  function automatic logic [HASH_W-1:0] char_value(input logic [CHAR_W-1:0] b);
    if (b >= CHAR_ORIGIN) begin
      return HASH_W'(b) - HASH_W'(CHAR_ORIGIN);
    end else begin
      return HASH_MOD - (HASH_W'(CHAR_ORIGIN) - HASH_W'(b));
    end
  endfunction

endpackage

[design/rhps_ring.sv]
// rhps_ring: history ring of recent text bytes, one write and one registered read port
// depends on rhps_pkg for parameter defaults; instantiated by rhps_datapath
`timescale 1ns / 1ps

module rhps_ring #(
  parameter int DEPTH  = rhps_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_W = $clog2(rhps_pkg::MAX_PATTERN_DEF),
  parameter int DATA_W = rhps_pkg::CHAR_W
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/rhps_datapath.sv]
// rhps_datapath: configuration registers, window state, barrett reducer and result register
// depends on rhps_pkg and rhps_ring; driven by rhps_ctrl commands
`timescale 1ns / 1ps

module rhps_datapath #(
  parameter int MAX_PATTERN = rhps_pkg::MAX_PATTERN_DEF,
  parameter int POS_BITS    = rhps_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rhps_pkg::ctrl_cmd_t             cmd_i,
  output rhps_pkg::ctrl_status_t          status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rhps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rhps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rhps_pkg::CHAR_W-1:0]     text_char_i,
  input  logic                            last_char_i,
  output logic                            res_valid_o,
  input  logic                            res_stall_i,
  output logic                            match_o,
  output logic [rhps_pkg::START_W-1:0]    match_start_o,
  output logic                            text_end_o
);

  localparam int HW = rhps_pkg::HASH_W;
  localparam int PW = rhps_pkg::PROD_W;
  localparam int MW = rhps_pkg::MU_W;
  localparam int RW = rhps_pkg::REM_W;
  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > rhps_pkg::LEN_CFG_W) ?
                         $clog2(MAX_PATTERN + 1) : rhps_pkg::LEN_CFG_W;
  localparam int SW = LEN_W + 1;
  localparam int CW = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam int XW = (POS_BITS > rhps_pkg::START_W) ? POS_BITS : rhps_pkg::START_W;

  // configuration
  logic [HW-1:0]                  pat_hash_q, pat_hash_d;
  logic [rhps_pkg::LEN_CFG_W-1:0] pat_len_q, pat_len_d;
  logic [HW-1:0]                  top_w_q, top_w_d;
  logic [HW-1:0]                  cfg_tw;
  logic                           cfg_we;

  // window state
  logic [HW-1:0]       h_q;
  logic [POS_BITS-1:0] idx_q;
  logic [PTR_W-1:0]    ptr_q, ptr_inc;

  // item and arithmetic
  logic [rhps_pkg::CHAR_W-1:0] byte_q;
  logic                        last_q;
  logic                        full_q;
  logic [PW-1:0]               prod_q, prod_d;
  logic [2*MW-1:0]             t_q, t_d;
  logic [RW-1:0]               qm_q, qm_d;
  logic [MW+HW-1:0]            qm_full;
  logic [RW-1:0]               r_q, r_d;
  logic [HW-1:0]               red_q, red_d;
  logic [HW-1:0]               hd_q, hd_d;
  logic [HW:0]                 mix_sum;

  // window geometry
  logic [LEN_W-1:0] len_ext, eff_len;
  logic [CW-1:0]    idx_c, len_c, start_c;
  logic [XW-1:0]    start_x;
  logic             full, reached;
  logic [SW-1:0]    slot_sum, slot;
  logic [PTR_W-1:0] rd_addr;
  logic [rhps_pkg::CHAR_W-1:0] ring_rd;

  // result register
  logic                         res_valid_q;
  logic                         match_q;
  logic [rhps_pkg::START_W-1:0] start_q;
  logic                         end_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_tw      = cfg_data_i[HW-1:0];

  always_comb begin
    pat_hash_d = pat_hash_q;
    pat_len_d  = pat_len_q;
    top_w_d    = top_w_q;
    unique case (cfg_index_i)
      rhps_pkg::CFG_PATTERN_HASH:   pat_hash_d = cfg_data_i[HW-1:0];
      rhps_pkg::CFG_PATTERN_LENGTH: pat_len_d  = cfg_data_i[rhps_pkg::LEN_CFG_W-1:0];
      // stored already reduced into the modulus
      rhps_pkg::CFG_TOP_WEIGHT: begin
        top_w_d = (cfg_tw >= rhps_pkg::HASH_MOD) ? cfg_tw - rhps_pkg::HASH_MOD : cfg_tw;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_hash_q <= '0;
      pat_len_q  <= rhps_pkg::LEN_CFG_W'(1);
      top_w_q    <= HW'(1);
    end else if (cfg_we) begin
      pat_hash_q <= pat_hash_d;
      pat_len_q  <= pat_len_d;
      top_w_q    <= top_w_d;
    end
  end

  // effective length, clamped to 1..MAX_PATTERN
  assign len_ext = LEN_W'(pat_len_q);
  always_comb begin
    priority if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = len_ext;
    end
  end

  assign idx_c   = CW'(idx_q);
  assign len_c   = CW'(eff_len);
  assign full    = idx_c >= len_c;
  assign reached = idx_c >= (len_c - CW'(1));
  assign start_c = idx_c - (len_c - CW'(1));
  assign start_x = XW'(start_c);

  // slot of the byte leaving the window
  assign slot_sum = SW'(ptr_q) + SW'(MAX_PATTERN) - SW'(eff_len);
  assign slot     = (slot_sum >= SW'(MAX_PATTERN)) ? slot_sum - SW'(MAX_PATTERN) : slot_sum;
  assign rd_addr  = slot[PTR_W-1:0];
  assign ptr_inc  = (ptr_q == PTR_W'(MAX_PATTERN - 1)) ? '0 : ptr_q + PTR_W'(1);

  rhps_ring #(
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (PTR_W),
    .DATA_W (rhps_pkg::CHAR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rd_en_i   (cmd_i.accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (ring_rd),
    .wr_en_i   (cmd_i.done),
    .wr_addr_i (ptr_q),
    .wr_data_i (byte_q)
  );

  // product feeding the reducer: drop term or shifted window plus new byte
  always_comb begin
    prod_d = prod_q;
    if (cmd_i.drop_mul) begin
      prod_d = PW'(top_w_q) * PW'(rhps_pkg::char_value(ring_rd));
    end else if (cmd_i.hash_mul) begin
      prod_d = PW'(hd_q) * PW'(rhps_pkg::HASH_BASE) + PW'(rhps_pkg::char_value(byte_q));
    end
  end

  // barrett: quotient estimate, its multiple, remainder, correction by up to two moduli
  assign t_d     = (2*MW)'(prod_q[PW-1:HW-1]) * (2*MW)'(rhps_pkg::BARRETT_MU);
  assign qm_full = (MW+HW)'(t_q[2*MW-1:HW+1]) * (MW+HW)'(rhps_pkg::HASH_MOD);
  assign qm_d    = qm_full[RW-1:0];
  assign r_d     = prod_q[RW-1:0] - qm_q;

  always_comb begin
    priority if (r_q >= rhps_pkg::MOD_X2) begin
      red_d = HW'(r_q - rhps_pkg::MOD_X2);
    end else if (r_q >= rhps_pkg::MOD_X1) begin
      red_d = HW'(r_q - rhps_pkg::MOD_X1);
    end else begin
      red_d = HW'(r_q);
    end
  end

  // window hash minus drop term, modulo
  assign mix_sum = (HW+1)'(h_q) + (HW+1)'(rhps_pkg::HASH_MOD) - (HW+1)'(red_q);
  always_comb begin
    if (!full_q) begin
      hd_d = h_q;
    end else if (mix_sum >= (HW+1)'(rhps_pkg::HASH_MOD)) begin
      hd_d = HW'(mix_sum - (HW+1)'(rhps_pkg::HASH_MOD));
    end else begin
      hd_d = HW'(mix_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= text_char_i;
      last_q <= last_char_i;
      full_q <= full;
    end
    if (cmd_i.drop_mul || cmd_i.hash_mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.red_q1) begin
      t_q <= t_d;
    end
    if (cmd_i.red_qm) begin
      qm_q <= qm_d;
    end
    if (cmd_i.red_sub) begin
      r_q <= r_d;
    end
    if (cmd_i.red_fix) begin
      red_q <= red_d;
    end
    if (cmd_i.hash_mix) begin
      hd_q <= hd_d;
    end
    if (cmd_i.done) begin
      match_q <= reached && (red_q == pat_hash_q);
      start_q <= reached ? start_x[rhps_pkg::START_W-1:0] : '0;
      end_q   <= last_q;
    end
  end

  // window state commit, cleared after the last byte of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      idx_q <= '0;
      ptr_q <= '0;
    end else if (cmd_i.done) begin
      if (last_q) begin
        h_q   <= '0;
        idx_q <= '0;
        ptr_q <= '0;
      end else begin
        h_q   <= red_q;
        ptr_q <= ptr_inc;
        if (idx_q != '1) begin
          idx_q <= idx_q + POS_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      res_valid_q <= 1'b1;
    end else if (res_valid_q && !res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign status_o.full     = full;
  assign status_o.out_busy = res_valid_q && res_stall_i;

  assign res_valid_o   = res_valid_q;
  assign match_o       = match_q;
  assign match_start_o = start_q;
  assign text_end_o    = end_q;

`ifndef SYNTH
  a_red_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.red_fix |=> red_q < rhps_pkg::HASH_MOD)
    else $error("reducer output not below modulus");

  a_mix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hash_mix |=> hd_q < rhps_pkg::HASH_MOD)
    else $error("window hash after drop not below modulus");

  a_hash_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_q < rhps_pkg::HASH_MOD)
    else $error("window hash not below modulus");

  a_text_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done && last_q |=> idx_q == '0 && ptr_q == '0 && h_q == '0)
    else $error("state not cleared after last byte");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> !(res_valid_q && res_stall_i))
    else $error("pending result overwritten");
`endif

endmodule

[design/rhps_ctrl.sv]
// rhps_ctrl: sequencer that steps one text byte through the drop and update reductions
// depends on rhps_pkg; drives rhps_datapath through command and status structs
`timescale 1ns / 1ps

module rhps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   text_valid_i,
  output logic                   text_stall_o,
  input  rhps_pkg::ctrl_status_t status_i,
  output rhps_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DROP_MUL = 9'b000000010,
    ST_RED_Q1   = 9'b000000100,
    ST_RED_QM   = 9'b000001000,
    ST_RED_SUB  = 9'b000010000,
    ST_RED_FIX  = 9'b000100000,
    ST_HASH_MIX = 9'b001000000,
    ST_HASH_MUL = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  // set once the reducer works on the updated window rather than the drop term
  logic   second_q, second_d;
  logic   accept;

  assign accept       = (state_q == ST_IDLE) && text_valid_i;
  assign text_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    unique case (state_q)
      ST_IDLE: begin
        if (text_valid_i) begin
          second_d = 1'b0;
          state_d  = status_i.full ? ST_DROP_MUL : ST_HASH_MIX;
        end
      end
      ST_DROP_MUL: state_d = ST_RED_Q1;
      ST_RED_Q1:   state_d = ST_RED_QM;
      ST_RED_QM:   state_d = ST_RED_SUB;
      ST_RED_SUB:  state_d = ST_RED_FIX;
      ST_RED_FIX:  state_d = second_q ? ST_DONE : ST_HASH_MIX;
      ST_HASH_MIX: state_d = ST_HASH_MUL;
      ST_HASH_MUL: begin
        second_d = 1'b1;
        state_d  = ST_RED_Q1;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.drop_mul = (state_q == ST_DROP_MUL);
    cmd_o.red_q1   = (state_q == ST_RED_Q1);
    cmd_o.red_qm   = (state_q == ST_RED_QM);
    cmd_o.red_sub  = (state_q == ST_RED_SUB);
    cmd_o.red_fix  = (state_q == ST_RED_FIX);
    cmd_o.hash_mix = (state_q == ST_HASH_MIX);
    cmd_o.hash_mul = (state_q == ST_HASH_MUL);
    cmd_o.done     = (state_q == ST_DONE) && !status_i.out_busy;
  end

endmodule

[design/rolling_hash_pattern_search_core.sv]
// rolling_hash_pattern_search_core: top level of the rolling hash pattern search
// depends on rhps_pkg, rhps_ctrl and rhps_datapath
`timescale 1ns / 1ps

// Usage
//   text channel: text_valid_i / text_stall_o with text_char_i and last_char_i. One byte
//   per transaction. last_char_i ends a text; window hash, index and ring pointer clear
//   once that byte's result is formed.
//   result channel: res_valid_o / res_stall_i with match_o, match_start_o and text_end_o.
//   Exactly one result per accepted byte, in order.
//   config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects pattern_hash (0),
//   pattern_length (1) or top_weight (2); other indexes are ignored. Ready is always high.
//   Write only while no byte is in flight.
// Sequencing
//   While the window is still filling, only the updated window passes through the
//   barrett reducer. With a full window the leaving byte's weight product and the
//   updated window both pass through the same four-stage barrett reducer, one after
//   the other. A new byte is taken only once the previous one has left the final step.
// Reset and stall
//   Reset clears the window state, restores the configuration defaults and empties the
//   result register. The history ring needs no clearing. A stalled result is held in the
//   output register while the next byte is taken and worked on; that byte then waits in
//   its final step until the register frees.

module rolling_hash_pattern_search_core #(
  parameter int MAX_PATTERN = rhps_pkg::MAX_PATTERN_DEF,
  parameter int POS_BITS    = rhps_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rhps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rhps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            text_valid_i,
  output logic                            text_stall_o,
  input  logic [rhps_pkg::CHAR_W-1:0]     text_char_i,
  input  logic                            last_char_i,
  output logic                            res_valid_o,
  input  logic                            res_stall_i,
  output logic                            match_o,
  output logic [rhps_pkg::START_W-1:0]    match_start_o,
  output logic                            text_end_o
);

  rhps_pkg::ctrl_cmd_t    cmd;
  rhps_pkg::ctrl_status_t status;

  rhps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_valid_i (text_valid_i),
    .text_stall_o (text_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rhps_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .POS_BITS    (POS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_char_i   (text_char_i),
    .last_char_i   (last_char_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .match_o       (match_o),
    .match_start_o (match_start_o),
    .text_end_o    (text_end_o)
  );

endmodule

[verif/tb.sv]
// tb: self-checking testbench for rolling_hash_pattern_search_core
// a scripted warm-up, then random texts checked against a rolling hash model
// depends on rhps_pkg and the core RTL
`timescale 1ns / 1ps

module tb;

  localparam longint unsigned MODULUS = longint'(rhps_pkg::HASH_MOD);
  localparam longint unsigned BASE = longint'(rhps_pkg::HASH_BASE);
  localparam longint unsigned ORIGIN = longint'(rhps_pkg::CHAR_ORIGIN);
  localparam int RING_DEPTH = rhps_pkg::MAX_PATTERN_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  // no register sits at this index, writes there must be ignored
  localparam logic [rhps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [rhps_pkg::CFG_IDX_W-1:0] CFG_IDX_LIST [4] = '{
    rhps_pkg::CFG_PATTERN_HASH, rhps_pkg::CFG_PATTERN_LENGTH, rhps_pkg::CFG_TOP_WEIGHT,
    CFG_IDX_SPARE
  };

  typedef struct packed {
    logic                         match;
    logic [rhps_pkg::START_W-1:0] start;
    logic                         text_end;
  } search_result_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic [rhps_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [rhps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic [rhps_pkg::CHAR_W-1:0]     ch;
    logic                            last;
    logic                            typed;
    logic                            exp_match;
    logic [rhps_pkg::START_W-1:0]    exp_start;
  } script_row_t;

  // typed rows carry their result, the rest go through the window model
  localparam script_row_t SCRIPT [28] = '{
    // reset config: length 1, hash 0, so only the byte just below 'a' hits
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd96, 1'b0, 1'b1, 1'b1, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd97, 1'b0, 1'b1, 1'b0, 32'd1},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd0, 1'b0, 1'b1, 1'b0, 32'd2},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd255, 1'b0, 1'b1, 1'b0, 32'd3},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd96, 1'b1, 1'b1, 1'b1, 32'd4},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd96, 1'b0, 1'b1, 1'b1, 32'd0},
    // zero length acts as one, upper data bits are dropped
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_LENGTH, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_HASH, 32'hC000_0001, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd97, 1'b0, 1'b1, 1'b1, 32'd1},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd98, 1'b0, 1'b1, 1'b0, 32'd2},
    // largest legal hash, reached by the byte just below the origin
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_HASH, 32'd1000000008, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd95, 1'b0, 1'b1, 1'b1, 32'd3},
    // oversized length, out-of-range weight and hash, spare index
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_LENGTH, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, rhps_pkg::CFG_TOP_WEIGHT, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_HASH, 32'h3FFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, CFG_IDX_SPARE, 32'd2, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd99, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd127, 1'b1, 1'b0, 1'b0, 32'd0},
    // pattern "abc": weight 31^2, hash 1*961 + 2*31 + 3
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_LENGTH, 32'd3, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, rhps_pkg::CFG_TOP_WEIGHT, 32'd961, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG, rhps_pkg::CFG_PATTERN_HASH, 32'd1026, 8'd0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd120, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd97, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd98, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd99, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd97, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd98, 1'b0, 1'b0, 1'b0, 32'd0},
    '{ROW_TEXT, rhps_pkg::CFG_PATTERN_HASH, 32'd0, 8'd99, 1'b1, 1'b0, 1'b0, 32'd0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [rhps_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [rhps_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            text_valid_i;
  logic                            text_stall_o;
  logic [rhps_pkg::CHAR_W-1:0]     text_char_i;
  logic                            last_char_i;
  logic                            res_valid_o;
  logic                            res_stall_i;
  logic                            match_o;
  logic [rhps_pkg::START_W-1:0]    match_start_o;
  logic                            text_end_o;

  // side band travelling with the text payload: a result typed into the script
  logic                            text_pinned;
  search_result_t                  pinned_result;

  // window model state and its copy of the registers
  logic [rhps_pkg::HASH_W-1:0]     cfg_pat_hash;
  logic [rhps_pkg::LEN_CFG_W-1:0]  cfg_pat_len;
  logic [rhps_pkg::HASH_W-1:0]     cfg_top_weight;
  logic [rhps_pkg::HASH_W-1:0]     win_hash;
  logic [rhps_pkg::START_W-1:0]    char_idx;
  logic [rhps_pkg::CHAR_W-1:0]     history [RING_DEPTH];
  logic [5:0]                      wr_ptr;

  search_result_t                  pending_results [$];
  int                              mismatches = 0;
  int                              quiet_cycles = 0;
  int                              sent_items = 0;
  int                              send_gap_pct = 37;
  int                              recv_stall_pct = 84;

  rolling_hash_pattern_search_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_valid_i  (text_valid_i),
    .text_stall_o  (text_stall_o),
    .text_char_i   (text_char_i),
    .last_char_i   (last_char_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .match_o       (match_o),
    .match_start_o (match_start_o),
    .text_end_o    (text_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // byte to residue, bytes below the origin wrap around the modulus
  function automatic longint unsigned residue_of(input logic [rhps_pkg::CHAR_W-1:0] b);
    if (b >= ORIGIN) begin
      return b - ORIGIN;
    end
    return MODULUS - (ORIGIN - b);
  endfunction

  // roll one byte through the window and return the result it produces
  function automatic search_result_t advance_window(input logic [rhps_pkg::CHAR_W-1:0] b,
                                                    input logic last);
    longint unsigned span;
    longint unsigned h;
    longint unsigned drop;
    logic [5:0]      old_slot;
    search_result_t  r;
    span = (cfg_pat_len == 0) ? 1 : ((cfg_pat_len > RING_DEPTH) ? RING_DEPTH : cfg_pat_len);
    h = win_hash % MODULUS;
    if (char_idx >= span) begin
      old_slot = 6'(wr_ptr + RING_DEPTH - span);
      drop = (cfg_top_weight % MODULUS) * residue_of(history[old_slot]) % MODULUS;
      h = (h + MODULUS - drop) % MODULUS;
    end
    h = (h * BASE + residue_of(b)) % MODULUS;
    history[wr_ptr] = b;
    r.match = 1'b0;
    r.start = '0;
    r.text_end = last;
    if (char_idx >= span - 1) begin
      r.start = rhps_pkg::START_W'(char_idx - (span - 1));
      r.match = (h == cfg_pat_hash);
    end
    if (last) begin
      win_hash = '0;
      char_idx = '0;
      wr_ptr = '0;
    end else begin
      win_hash = rhps_pkg::HASH_W'(h);
      if (char_idx != '1) char_idx++;
      wr_ptr++;
    end
    return r;
  endfunction

  // receiver back-pressure
  initial begin
    res_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      res_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // observe all three channels, keep the model in step, compare results
  always @(posedge clk_i) begin
    search_result_t want;
    if (!rst_ni) begin
      cfg_pat_hash = '0;
      cfg_pat_len = rhps_pkg::LEN_CFG_W'(1);
      cfg_top_weight = rhps_pkg::HASH_W'(1);
      win_hash = '0;
      char_idx = '0;
      wr_ptr = '0;
    end else begin
      quiet_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles = 0;
        case (cfg_index_i)
          rhps_pkg::CFG_PATTERN_HASH:   cfg_pat_hash = cfg_data_i[rhps_pkg::HASH_W-1:0];
          rhps_pkg::CFG_PATTERN_LENGTH: cfg_pat_len = cfg_data_i[rhps_pkg::LEN_CFG_W-1:0];
          rhps_pkg::CFG_TOP_WEIGHT:     cfg_top_weight = cfg_data_i[rhps_pkg::HASH_W-1:0];
          default: ;
        endcase
      end
      if (text_valid_i && !text_stall_o) begin
        quiet_cycles = 0;
        want = advance_window(text_char_i, last_char_i);
        if (text_pinned) want = pinned_result;
        pending_results.push_back(want);
      end
      if (res_valid_o && !res_stall_i) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing pending: match %0d start %0d end %0d",
                 match_o, match_start_o, text_end_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (match_o !== want.match) begin
            $error("match: expected %0d, actual %0d", want.match, match_o);
            mismatches++;
          end
          if (match_start_o !== want.start) begin
            $error("match_start: expected %0d, actual %0d", want.start, match_start_o);
            mismatches++;
          end
          if (text_end_o !== want.text_end) begin
            $error("text_end: expected %0d, actual %0d", want.text_end, text_end_o);
            mismatches++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // valid stays high into the next call unless that call opens a gap
  task automatic send_byte(input logic [rhps_pkg::CHAR_W-1:0] ch, input logic last,
                           input logic pin, input search_result_t pin_res);
    while ($urandom_range(99) < send_gap_pct) begin
      text_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    text_valid_i <= 1'b1;
    text_char_i <= ch;
    last_char_i <= last;
    text_pinned <= pin;
    pinned_result <= pin_res;
    @(posedge clk_i);
    while (text_stall_o) @(posedge clk_i);
    sent_items++;
  endtask

  // register writes only once every pending transaction has come back
  task automatic cfg_write(input logic [rhps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rhps_pkg::CFG_DATA_W-1:0] data);
    text_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // tidy: a real pattern with consistent weight and hash, text seeded with copies
  // otherwise: raw register values and raw bytes
  task automatic run_search_segment(input bit tidy);
    int                              span;
    int                              n;
    logic [rhps_pkg::CHAR_W-1:0]     lo;
    logic [rhps_pkg::CHAR_W-1:0]     hi;
    logic [rhps_pkg::CHAR_W-1:0]     pattern [RING_DEPTH];
    longint unsigned                 pat_hash;
    longint unsigned                 weight;
    logic [rhps_pkg::CHAR_W-1:0]     text_buf [$];
    logic [rhps_pkg::CFG_DATA_W-1:0] data;
    logic                            last;
    if (tidy) begin
      case ($urandom_range(9))
        0:       span = RING_DEPTH;
        1, 2:    span = $urandom_range(RING_DEPTH - 1, 7);
        default: span = $urandom_range(6, 1);
      endcase
      lo = 8'd97;
      hi = 8'(97 + $urandom_range(3, 1));
      if ($urandom_range(4) == 0) begin
        lo = 8'd0;
        hi = 8'd255;
      end
      pat_hash = 0;
      weight = 1;
      for (int k = 0; k < span; k++) begin
        pattern[k] = 8'($urandom_range(hi, lo));
        pat_hash = (pat_hash * BASE + residue_of(pattern[k])) % MODULUS;
        if (k > 0) weight = weight * BASE % MODULUS;
      end
      cfg_write(rhps_pkg::CFG_PATTERN_LENGTH, 32'(span));
      cfg_write(rhps_pkg::CFG_TOP_WEIGHT, 32'(weight));
      cfg_write(rhps_pkg::CFG_PATTERN_HASH, 32'(pat_hash));
      n = span + $urandom_range(40, 8);
      while (text_buf.size() < n) begin
        if ($urandom_range(3) == 0) begin
          for (int k = 0; k < span; k++) text_buf.push_back(pattern[k]);
        end else begin
          text_buf.push_back(8'($urandom_range(hi, lo)));
        end
      end
    end else begin
      foreach (CFG_IDX_LIST[k]) begin
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0:       data = '0;
            1:       data = '1;
            2:       data = 32'(MODULUS - 1);
            default: data = $urandom();
          endcase
          cfg_write(CFG_IDX_LIST[k], data);
        end
      end
      n = $urandom_range(40, 8);
      repeat (n) text_buf.push_back(8'($urandom()));
    end
    foreach (text_buf[j]) begin
      if (j == text_buf.size() - 1) last = ($urandom_range(4) != 0);
      else last = ($urandom_range(tidy ? 59 : 7) == 0);
      send_byte(text_buf[j], last, 1'b0, '0);
    end
  endtask

  initial begin
    search_result_t typed_res;
    int             base;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rhps_pkg::CFG_PATTERN_HASH;
    cfg_data_i = '0;
    text_valid_i = 1'b0;
    text_char_i = '0;
    last_char_i = 1'b0;
    text_pinned = 1'b0;
    pinned_result = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        cfg_write(SCRIPT[i].cfg_idx, SCRIPT[i].cfg_data);
      end else begin
        typed_res.match = SCRIPT[i].exp_match;
        typed_res.start = SCRIPT[i].exp_start;
        typed_res.text_end = SCRIPT[i].last;
        send_byte(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].typed, typed_res);
      end
    end

    base = sent_items;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 37;
          recv_stall_pct = 84;
        end
        1: begin
          send_gap_pct = 84;
          recv_stall_pct = 37;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (sent_items - base < RANDOM_ITEMS * (phase + 1) / 3) begin
        run_search_segment($urandom_range(9) < 7);
      end
    end

    text_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rhps_pkg.sv
design/rhps_ring.sv
design/rhps_datapath.sv
design/rhps_ctrl.sv
design/rolling_hash_pattern_search_core.sv
verif/tb.sv
